[rtl/rkcc_pkg.sv]
package rkcc_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int KERNEL_SPAN_DEF = 5;

  localparam int PIX_W       = 8;
  localparam int PIX_MAX     = 255;
  localparam int CHAN        = 3;
  localparam int COEF_W      = 12;
  localparam int COEF_TAPS   = 5;
  localparam int COEF_RADIUS = (COEF_TAPS - 1) / 2;
  localparam int ROW_W       = COEF_TAPS * COEF_W;
  localparam int FRAC_W      = 4;
  localparam int FRAC_MAX    = 8;
  localparam int IMG_W_W     = 11;
  localparam int IMG_H_W     = 16;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;
  localparam int CFG_IDX_W   = 3;

  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int SUM_W  = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF0,
    REG_COEF1,
    REG_COEF2,
    REG_COEF3,
    REG_COEF4,
    REG_FRAC,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef logic [COEF_TAPS-1:0][ROW_W-1:0] coef_rows_t;

  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

endpackage

[rtl/rkcc_ram.sv]
module rkcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rkcc_ctrl.sv]
module rkcc_ctrl #(
  parameter int MAX_WIDTH   = rkcc_pkg::MAX_WIDTH_DEF,
  parameter int KERNEL_SPAN = rkcc_pkg::KERNEL_SPAN_DEF,
  localparam int RADIUS = (KERNEL_SPAN - 1) / 2,
  localparam int SPAN   = 2 * RADIUS + 1,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int WID_W  = COL_W + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         filler,
  input  logic                         clear,
  input  logic [WID_W-1:0]             w_eff,
  input  logic [rkcc_pkg::IMG_H_W-1:0] h_eff,
  output logic                         advance,
  output rkcc_pkg::tag_t               tag,
  output logic [COL_W-1:0]             column,
  output logic [SPAN-1:0]              col_ok,
  output logic [SPAN-1:0]              row_ok
);

  import rkcc_pkg::*;

  localparam int DELAY_MAX = RADIUS * MAX_WIDTH + RADIUS;
  localparam int LEAD_W    = $clog2(DELAY_MAX + 1);
  localparam int XW        = WID_W + 1;
  localparam int YW        = IMG_H_W + 2;

  logic [COL_W-1:0]   in_column;
  logic [IMG_H_W:0]   in_row;
  logic [COL_W-1:0]   out_column;
  logic [IMG_H_W-1:0] out_row;
  logic [LEAD_W-1:0]  lead;

  logic [LEAD_W-1:0] delay;
  logic              in_frame;
  logic              primed;
  logic              in_col_last;
  logic              out_col_last;

  assign delay        = LEAD_W'(RADIUS * w_eff + RADIUS);
  assign in_frame     = in_row < (IMG_H_W + 1)'(h_eff);
  assign primed       = lead == delay;
  assign in_col_last  = {1'b0, in_column} == w_eff - WID_W'(1);
  assign out_col_last = {1'b0, out_column} == w_eff - WID_W'(1);

  assign advance  = !(in_frame && filler);
  assign tag.emit = advance && primed;
  assign tag.last = out_col_last && (out_row == h_eff - IMG_H_W'(1));
  assign column   = in_column;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      lead       <= '0;
    end else if (accept && advance) begin
      if (tag.emit && tag.last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        lead       <= '0;
      end else begin
        if (in_col_last) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
        if (!primed) begin
          lead <= lead + 1'b1;
        end
        if (tag.emit) begin
          if (out_col_last) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end
      end
    end
  end

  // A tap is inside the frame when the center plus its offset lands in 0..size-1.
  for (genvar i = 0; i < SPAN; i++) begin : g_mask
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    assign xs        = XW'(out_column) + XW'(i);
    assign ys        = YW'(out_row) + YW'(i);
    assign col_ok[i] = (xs >= XW'(RADIUS)) && (xs < XW'(w_eff) + XW'(RADIUS));
    assign row_ok[i] = (ys >= YW'(RADIUS)) && (ys < YW'(h_eff) + YW'(RADIUS));
  end

  a_in_column_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_column} < w_eff)
    else $error("input column outside the row");

  a_out_column_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_column} < w_eff)
    else $error("output column outside the row");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && advance && tag.emit && tag.last |=>
      in_column == '0 && in_row == '0 && out_row == '0 && lead == '0)
    else $error("counters not cleared after the last pixel of a frame");

endmodule

[rtl/rkcc_window.sv]
module rkcc_window #(
  parameter int MAX_WIDTH   = rkcc_pkg::MAX_WIDTH_DEF,
  parameter int KERNEL_SPAN = rkcc_pkg::KERNEL_SPAN_DEF,
  localparam int RADIUS = (KERNEL_SPAN - 1) / 2,
  localparam int SPAN   = 2 * RADIUS + 1,
  localparam int COL_W  = $clog2(MAX_WIDTH)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  run,
  input  logic                                  load,
  input  rkcc_pkg::rgb_t                        pix,
  input  logic [COL_W-1:0]                      column,
  input  rkcc_pkg::tag_t                        tag,
  input  logic [SPAN-1:0]                       col_ok,
  input  logic [SPAN-1:0]                       row_ok,
  output rkcc_pkg::rgb_t [SPAN-1:0][SPAN-1:0]   win,
  output logic                                  win_valid,
  output rkcc_pkg::tag_t                        win_tag,
  output logic [SPAN-1:0]                       win_col_ok,
  output logic [SPAN-1:0]                       win_row_ok
);

  import rkcc_pkg::*;

  localparam int NBUF = 2 * RADIUS;

  logic             s1_valid;
  rgb_t             s1_pix;
  logic [COL_W-1:0] s1_col;
  tag_t             s1_tag;
  logic [SPAN-1:0]  s1_col_ok;
  logic [SPAN-1:0]  s1_row_ok;

  logic re;
  logic we;
  rgb_t rd [NBUF];
  rgb_t wd [NBUF];
  rgb_t rdv [NBUF];
  logic byp;
  rgb_t byp_data [NBUF];
  rgb_t [SPAN-1:0] newcol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (run) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (run && load) begin
      s1_pix    <= pix;
      s1_col    <= column;
      s1_tag    <= tag;
      s1_col_ok <= col_ok;
      s1_row_ok <= row_ok;
    end
  end

  assign re = run && load;
  assign we = run && s1_valid;

  // With a one-pixel row the next read hits the address being written, so
  // the written data is kept and used in place of the stale read.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (re) begin
      byp <= we && (s1_col == column);
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      byp_data <= wd;
    end
  end

  assign newcol[0] = s1_pix;

  for (genvar j = 0; j < NBUF; j++) begin : g_line
    rkcc_ram #(
      .WIDTH($bits(rgb_t)),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (we),
      .waddr(s1_col),
      .wdata(wd[j]),
      .re   (re),
      .raddr(column),
      .rdata(rd[j])
    );

    assign rdv[j]        = byp ? byp_data[j] : rd[j];
    assign newcol[j + 1] = rdv[j];
    assign wd[j]         = newcol[j];
  end

  always_ff @(posedge clk) begin
    if (run && s1_valid) begin
      for (int i = 0; i < SPAN - 1; i++) begin
        win[i] <= win[i + 1];
      end
      for (int r = 0; r < SPAN; r++) begin
        win[SPAN-1][r] <= newcol[SPAN-1-r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (run) begin
      win_valid <= s1_valid && s1_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (run && s1_valid) begin
      win_tag    <= s1_tag;
      win_col_ok <= s1_col_ok;
      win_row_ok <= s1_row_ok;
    end
  end

endmodule

[rtl/rkcc_mac.sv]
module rkcc_mac #(
  parameter int KERNEL_SPAN = rkcc_pkg::KERNEL_SPAN_DEF,
  localparam int RADIUS = (KERNEL_SPAN - 1) / 2,
  localparam int SPAN   = 2 * RADIUS + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                run,
  input  logic                                in_valid,
  input  rkcc_pkg::tag_t                      in_tag,
  input  rkcc_pkg::rgb_t [SPAN-1:0][SPAN-1:0] win,
  input  logic [SPAN-1:0]                     col_ok,
  input  logic [SPAN-1:0]                     row_ok,
  input  rkcc_pkg::coef_rows_t                coef,
  input  logic [rkcc_pkg::FRAC_W-1:0]         frac,
  output logic                                res_valid,
  output logic                                res_last,
  output rkcc_pkg::rgb_t                      res_pix
);

  import rkcc_pkg::*;

  logic signed [COEF_W-1:0]           cf [SPAN][SPAN];
  logic [CHAN-1:0][PIX_W-1:0]         px [SPAN][SPAN];
  logic signed [PROD_W-1:0]           prod [SPAN][SPAN][CHAN];
  logic signed [SUM_W-1:0]            colsum_next [CHAN][SPAN];
  logic signed [SUM_W-1:0]            colsum [CHAN][SPAN];
  logic signed [SUM_W-1:0]            total_next [CHAN];
  logic signed [SUM_W-1:0]            total [CHAN];
  logic [CHAN-1:0][PIX_W-1:0]         res_ch;
  logic                               s3_valid;
  logic                               s4_valid;
  logic                               s3_last;
  logic                               s4_last;

  function automatic logic [PIX_W-1:0] finish(input logic signed [SUM_W-1:0] s,
                                              input logic [FRAC_W-1:0] f);
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] half;
    logic [SUM_W-1:0] rnd;
    logic [PIX_W-1:0] res;
    lim  = SUM_W'(PIX_MAX) << f;
    half = (f == '0) ? '0 : (SUM_W'(1) << (f - 1'b1));
    rnd  = $unsigned(s) + half;
    if (s <= 0) begin
      res = '0;
    end else if ($unsigned(s) > lim) begin
      res = PIX_W'(PIX_MAX);
    end else begin
      res = PIX_W'(rnd >> f);
    end
    return res;
  endfunction

  // The kernel is flipped: window column i lies at x offset i-RADIUS and takes kernel x offset RADIUS-i.
  for (genvar i = 0; i < SPAN; i++) begin : g_col
    for (genvar r = 0; r < SPAN; r++) begin : g_row
      localparam int M = RADIUS - i;
      localparam int N = RADIUS - r;
      if (M >= -COEF_RADIUS && M <= COEF_RADIUS && N >= -COEF_RADIUS && N <= COEF_RADIUS)
      begin : g_coef
        assign cf[i][r] = coef[M + COEF_RADIUS][(N + COEF_RADIUS) * COEF_W +: COEF_W];
      end else begin : g_zero
        assign cf[i][r] = '0;
      end
      assign px[i][r] = (col_ok[i] && row_ok[r]) ? win[i][r] : win[RADIUS][RADIUS];
    end
  end

  always_ff @(posedge clk) begin
    if (run && in_valid) begin
      for (int i = 0; i < SPAN; i++) begin
        for (int r = 0; r < SPAN; r++) begin
          for (int c = 0; c < CHAN; c++) begin
            prod[i][r][c] <= cf[i][r] * $signed({1'b0, px[i][r][c]});
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHAN; c++) begin
      for (int i = 0; i < SPAN; i++) begin
        colsum_next[c][i] = '0;
        for (int r = 0; r < SPAN; r++) begin
          colsum_next[c][i] = colsum_next[c][i] + SUM_W'(prod[i][r][c]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHAN; c++) begin
      total_next[c] = '0;
      for (int i = 0; i < SPAN; i++) begin
        total_next[c] = total_next[c] + colsum[c][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run && s3_valid) begin
      colsum <= colsum_next;
    end
    if (run && s4_valid) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (run) begin
      s3_valid  <= in_valid;
      s4_valid  <= s3_valid;
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s3_last  <= in_tag.last;
      s4_last  <= s3_last;
      res_last <= s4_last;
    end
  end

  for (genvar c = 0; c < CHAN; c++) begin : g_finish
    assign res_ch[c] = finish(total[c], frac);
  end

  assign res_pix = res_ch;

endmodule

[rtl/rgb_kernel_convolution_clamp.sv]
// Channel   Direction  Content
// s_axis    in         tdata: red, green, blue; tuser: is_filler
// m_axis    out        tdata: out_red, out_green, out_blue; tlast: last_of_frame
// cfg       in         cfg_index selects the register, cfg_data is written when cfg_we is high
//
// One pixel transaction is taken per clock unless m_axis stalls; the line buffers are read
// and written once per pixel, one RAM per kernel row above the newest, and the kernel taps
// are parallel. A result passes the window input, window, product, column-sum, total and
// output registers. All stages and s_axis_tready advance together whenever the output register
// is empty or being read; a stall on m_axis holds every stage.
// rst clears the counters and the pipeline valid flags and resets the configuration registers.
// The line buffers are not cleared: out-of-frame rows are replaced by the center pixel.
module rgb_kernel_convolution_clamp #(
  parameter int MAX_WIDTH   = rkcc_pkg::MAX_WIDTH_DEF,
  parameter int KERNEL_SPAN = rkcc_pkg::KERNEL_SPAN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // red, green, blue
  input  logic                           s_axis_tuser,   // is_filler
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // out_red, out_green, out_blue
  output logic                           m_axis_tlast,   // last_of_frame
  input  logic                           cfg_we,
  input  logic [rkcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rkcc_pkg::ROW_W-1:0]     cfg_data
);

  import rkcc_pkg::*;

  localparam int RADIUS = (KERNEL_SPAN - 1) / 2;
  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;

  coef_rows_t         coef_rows;
  logic [FRAC_W-1:0]  frac_bits;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  logic [WID_W-1:0]   w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [FRAC_W-1:0]  frac_eff;
  logic               size_write;

  logic run;
  logic accept;
  rgb_t in_pix;

  logic             advance;
  tag_t             in_tag;
  logic [COL_W-1:0] in_col;
  logic [SPAN-1:0]  col_ok;
  logic [SPAN-1:0]  row_ok;

  rgb_t [SPAN-1:0][SPAN-1:0] win;
  logic                      win_valid;
  tag_t                      win_tag;
  logic [SPAN-1:0]           win_col_ok;
  logic [SPAN-1:0]           win_row_ok;

  logic res_valid;
  logic res_last;
  rgb_t res_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows    <= '0;
      frac_bits    <= '0;
      image_width  <= IMG_W_W'(WIDTH_RESET);
      image_height <= IMG_H_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4: begin
          coef_rows[cfg_index] <= cfg_data;
        end
        REG_FRAC:   frac_bits    <= cfg_data[FRAC_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_write = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_comb begin
    if (image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(image_width);
    end
    h_eff    = (image_height == '0) ? IMG_H_W'(1) : image_height;
    frac_eff = (frac_bits > FRAC_W'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX) : frac_bits;
  end

  assign run           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = run;
  assign accept        = s_axis_tvalid && run;
  assign in_pix        = s_axis_tdata;

  rkcc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .KERNEL_SPAN(KERNEL_SPAN)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .filler (s_axis_tuser),
    .clear  (size_write),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .advance(advance),
    .tag    (in_tag),
    .column (in_col),
    .col_ok (col_ok),
    .row_ok (row_ok)
  );

  rkcc_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .KERNEL_SPAN(KERNEL_SPAN)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .load      (accept && advance),
    .pix       (in_pix),
    .column    (in_col),
    .tag       (in_tag),
    .col_ok    (col_ok),
    .row_ok    (row_ok),
    .win       (win),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .win_col_ok(win_col_ok),
    .win_row_ok(win_row_ok)
  );

  rkcc_mac #(
    .KERNEL_SPAN(KERNEL_SPAN)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_valid (win_valid),
    .in_tag   (win_tag),
    .win      (win),
    .col_ok   (win_col_ok),
    .row_ok   (win_row_ok),
    .coef     (coef_rows),
    .frac     (frac_eff),
    .res_valid(res_valid),
    .res_last (res_last),
    .res_pix  (res_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (run) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run && res_valid) begin
      m_axis_tdata <= res_pix;
      m_axis_tlast <= res_last;
    end
  end

endmodule

[tb/rgb_kernel_convolution_clamp_tb.sv]
module rgb_kernel_convolution_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rkcc_pkg::*;

  localparam int HIST_DEPTH = 2 * COEF_RADIUS * MAX_WIDTH_DEF + 2 * COEF_RADIUS + 1;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES = 20;
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_TARGET = 850;

  typedef enum int {KERN_WIDE, KERN_NARROW, KERN_3X3} kernel_style_t;

  typedef struct {
    rgb_t pix;
    logic last;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  rgb_t s_axis_tdata = '0;      // red, green, blue
  logic s_axis_tuser = 1'b0;    // is_filler
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  rgb_t m_axis_tdata;           // out_red, out_green, out_blue
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  // Shadow of the block: pixel history, kernel, scaling, frame size and positions.
  rgb_t pix_hist [HIST_DEPTH];
  logic [ROW_W-1:0] kern_row [COEF_TAPS] = '{default: '0};
  logic [FRAC_W-1:0] frac_cfg = '0;
  logic [IMG_W_W-1:0] width_cfg = IMG_W_W'(WIDTH_RESET);
  logic [IMG_H_W-1:0] height_cfg = IMG_H_W'(HEIGHT_RESET);
  int unsigned in_x = 0, in_y = 0, res_x = 0, res_y = 0;

  conv_result_t conv_expected [$];
  int mismatch_count = 0;
  int unsigned advancing_items = 0;
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;

  rgb_kernel_convolution_clamp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned cols_eff();
    if (width_cfg == 0) return 1;
    if (width_cfg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(width_cfg);
  endfunction

  function automatic int unsigned rows_eff();
    return (height_cfg == 0) ? 1 : 32'(height_cfg);
  endfunction

  function automatic void clear_positions();
    in_x = 0;
    in_y = 0;
    res_x = 0;
    res_y = 0;
  endfunction

  function automatic logic [PIX_W-1:0] round_clamp(int s, int unsigned f);
    if (s <= 0) return '0;
    if (s > (PIX_MAX << f)) return PIX_W'(PIX_MAX);
    return PIX_W'((s + ((f == 0) ? 0 : (1 << (f - 1)))) >> f);
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px = 24'($urandom());
    return px;
  endfunction

  task automatic predict_conv_pixel(input rgb_t px, input logic filler);
    int unsigned w, h, total, lag, pos, k, frac;
    int sx, sy, cf;
    int acc [3];
    rgb_t ctr, tap;
    conv_result_t res;
    w = cols_eff();
    h = rows_eff();
    total = w * h;
    lag = COEF_RADIUS * w + COEF_RADIUS;
    pos = in_y * w + in_x;
    if (pos < total) begin
      if (filler) return;
      pix_hist[pos % HIST_DEPTH] = px;
    end
    advancing_items++;
    in_x++;
    if (in_x >= w) begin
      in_x = 0;
      in_y++;
    end
    if (pos < lag) return;

    k = res_y * w + res_x;
    ctr = pix_hist[k % HIST_DEPTH];
    acc = '{0, 0, 0};
    for (int m = -COEF_RADIUS; m <= COEF_RADIUS; m++) begin
      for (int n = -COEF_RADIUS; n <= COEF_RADIUS; n++) begin
        sx = int'(res_x) - m;
        sy = int'(res_y) - n;
        cf = $signed(kern_row[m + COEF_RADIUS][COEF_W * (n + COEF_RADIUS) +: COEF_W]);
        tap = ctr;
        if (sx >= 0 && sy >= 0 && sx < int'(w) && sy < int'(h))
          tap = pix_hist[(sy * int'(w) + sx) % HIST_DEPTH];
        acc[0] += cf * int'(tap.red);
        acc[1] += cf * int'(tap.green);
        acc[2] += cf * int'(tap.blue);
      end
    end
    frac = (frac_cfg > FRAC_MAX) ? FRAC_MAX : frac_cfg;
    res.pix.red = round_clamp(acc[0], frac);
    res.pix.green = round_clamp(acc[1], frac);
    res.pix.blue = round_clamp(acc[2], frac);
    res.last = (k + 1 >= total);
    conv_expected.push_back(res);
    if (res.last) begin
      clear_positions();
    end else begin
      res_x++;
      if (res_x >= w) begin
        res_x = 0;
        res_y++;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input rgb_t px, input logic filler);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= filler;
    do @(posedge clk); while (!s_axis_tready);
    predict_conv_pixel(px, filler);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ROW_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAC: frac_cfg = value[FRAC_W-1:0];
      REG_WIDTH: begin
        width_cfg = value[IMG_W_W-1:0];
        clear_positions();
      end
      REG_HEIGHT: begin
        height_cfg = value[IMG_H_W-1:0];
        clear_positions();
      end
      default: kern_row[int'(idx)] = value;
    endcase
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (conv_expected.size() != 0);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_random_kernel();
    kernel_style_t style;
    logic [ROW_W-1:0] row;
    style = kernel_style_t'($urandom_range(0, 2));
    for (int r = 0; r < COEF_TAPS; r++) begin
      row = '0;
      for (int k = 0; k < COEF_TAPS; k++) begin
        case (style)
          KERN_WIDE: row[k * COEF_W +: COEF_W] = COEF_W'($urandom());
          KERN_NARROW: row[k * COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16) - 8);
          default: begin
            if (r > 0 && r < COEF_TAPS - 1 && k > 0 && k < COEF_TAPS - 1)
              row[k * COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16) - 8);
          end
        endcase
      end
      write_reg(reg_idx_t'(r), row);
    end
    write_reg(REG_FRAC,
              ROW_W'((style == KERN_WIDE) ? $urandom_range(6, 15) : $urandom_range(0, 5)));
  endtask

  // Sends n_pix pixels of the current frame with occasional bubbles, then the flush tail if with_tail.
  task automatic stream_frame(input int unsigned n_pix, input bit with_tail);
    int unsigned pause_at;
    pause_at = $urandom_range(0, n_pix);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (i == pause_at && $urandom_range(0, 3) == 0) hold_until_drained();
      if ($urandom_range(0, 9) == 0) send_item(rand_pixel(), 1'b1);
      send_item(rand_pixel(), 1'b0);
    end
    if (with_tail) begin
      for (int unsigned i = 0; i < COEF_RADIUS * cols_eff() + COEF_RADIUS; i++)
        send_item(rand_pixel(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed_frame();
    rgb_t pattern [6];
    pattern = '{24'h000000, 24'hFFFFFF, 24'h55AA55, 24'hAA55AA, 24'h0180FF, 24'hFE7F00};
    // P(x,y) + P(x-1,y) - P(x+1,y+1), halved with rounding.
    write_reg(REG_COEF0, '0);
    write_reg(REG_COEF1, ROW_W'(12'hFFF) << COEF_W);
    write_reg(REG_COEF2, ROW_W'(1) << (2 * COEF_W));
    write_reg(REG_COEF3, ROW_W'(1) << (2 * COEF_W));
    write_reg(REG_COEF4, '0);
    write_reg(REG_FRAC, ROW_W'(1));
    write_reg(REG_WIDTH, ROW_W'(3));
    write_reg(REG_HEIGHT, ROW_W'(2));
    for (int i = 0; i < 6; i++) begin
      if (i == 3) send_item(pattern[1], 1'b1);
      send_item(pattern[i], 1'b0);
    end
    hold_until_drained();
    for (int i = 0; i < 2 * 3 + 2; i++)
      send_item(pattern[i % 6], 1'(i % 2));
    wait_idle();
  endtask

  task automatic test_single_pixel_frames();
    write_reg(REG_WIDTH, ROW_W'(0));
    write_reg(REG_HEIGHT, ROW_W'(0));
    write_reg(REG_FRAC, ROW_W'(15));
    for (int r = 0; r < COEF_TAPS; r++)
      write_reg(reg_idx_t'(r), {COEF_TAPS{12'h7FF}});
    send_item(24'h01FF00, 1'b0);
    repeat (4) send_item(24'h000000, 1'b1);
    wait_idle();
    for (int r = 0; r < COEF_TAPS; r++)
      write_reg(reg_idx_t'(r), (r == COEF_RADIUS) ? ROW_W'(1) << (2 * COEF_W) : '0);
    write_reg(REG_FRAC, ROW_W'(1));
    send_item(24'h030201, 1'b0);
    send_item(24'hFFFFFF, 1'b0);
    send_item(24'h000000, 1'b1);
    send_item(24'h808080, 1'b0);
    send_item(24'h000000, 1'b1);
    wait_idle();
  endtask

  task automatic test_size_change();
    src_steady = 1'b1;
    sink_steady = 1'b1;
    write_reg(REG_WIDTH, ROW_W'(2047));
    write_reg(REG_HEIGHT, ROW_W'(16'hFFFF));
    load_random_kernel();
    stream_frame(60, 1'b0);
    wait_idle();
    src_steady = 1'b0;
    sink_steady = 1'b0;
    write_reg(REG_WIDTH, ROW_W'(3));
    write_reg(REG_HEIGHT, ROW_W'(2));
    stream_frame(6, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned total, cut;
    bit keep_size;
    keep_size = 1'b0;
    advancing_items = 0;
    while (advancing_items < RANDOM_TARGET) begin
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if (!keep_size) begin
        wait_idle();
        write_reg(REG_WIDTH,
                  ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(0, 8)));
        write_reg(REG_HEIGHT,
                  ROW_W'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(0, 6)));
        if ($urandom_range(0, 1) == 1) load_random_kernel();
      end
      total = cols_eff() * rows_eff();
      case ($urandom_range(0, 5))
        0: begin
          cut = $urandom_range(0, total);
          stream_frame(cut, 1'b0);
          wait_idle();
          load_random_kernel();
          stream_frame(total - cut, 1'b1);
          keep_size = ($urandom_range(0, 1) == 1);
        end
        1: begin
          stream_frame($urandom_range(0, total), 1'b0);
          keep_size = 1'b0;
        end
        default: begin
          stream_frame(total, 1'b1);
          keep_size = ($urandom_range(0, 2) == 0);
        end
      endcase
    end
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (conv_expected.size() == 0) begin
        report_mismatch($sformatf("result %h last %b with nothing expected",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = conv_expected.pop_front();
        if (m_axis_tdata.red !== want.pix.red)
          report_mismatch($sformatf("out_red got %0d expected %0d",
                                    m_axis_tdata.red, want.pix.red));
        if (m_axis_tdata.green !== want.pix.green)
          report_mismatch($sformatf("out_green got %0d expected %0d",
                                    m_axis_tdata.green, want.pix.green));
        if (m_axis_tdata.blue !== want.pix.blue)
          report_mismatch($sformatf("out_blue got %0d expected %0d",
                                    m_axis_tdata.blue, want.pix.blue));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last_of_frame got %b expected %b",
                                    m_axis_tlast, want.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frame();
    test_single_pixel_frames();
    test_size_change();
    test_random_frames();
    hold_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rkcc_pkg.sv
rtl/rkcc_ram.sv
rtl/rkcc_ctrl.sv
rtl/rkcc_window.sv
rtl/rkcc_mac.sv
rtl/rgb_kernel_convolution_clamp.sv
tb/rgb_kernel_convolution_clamp_tb.sv
